// File: src/swcb_pkg.sv
`default_nettype none
package swcb_pkg;

  localparam int STAMP_W = 32;
  localparam int FAIL_SLOTS_DEF = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CATASTROPHE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HINTS_ENABLE   = 3'd5;

  localparam logic [6:0]  FAIL_LIMIT_RST     = 7'd5;
  localparam logic [7:0]  SUCCESS_LIMIT_RST  = 8'd2;
  localparam logic [31:0] OPEN_TIMEOUT_RST   = 32'd30000;
  localparam logic [31:0] WINDOW_LEN_RST     = 32'd10000;
  localparam logic [6:0]  CATASTROPHE_RST    = 7'd20;
  localparam logic        HINTS_ENABLE_RST   = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } swcb_mode_t;

  typedef enum logic [1:0] {
    REQ_ALLOW   = 2'd0,
    REQ_SUCCESS = 2'd1,
    REQ_FAIL    = 2'd2,
    REQ_FORCE   = 2'd3
  } swcb_req_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PRUNE = 2'd1,
    ST_EMIT  = 2'd2
  } swcb_fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
  } swcb_in_t;

  typedef struct packed {
    logic        allowed;
    logic [1:0]  breaker_state;
    logic [6:0]  window_failures;
    logic        catastrophe_hint;
    logic [31:0] rejected_total;
    logic [31:0] transitions_total;
    logic [31:0] failures_total;
    logic [31:0] successes_total;
  } swcb_out_t;

  // ring control from the sequencer to the stamp chain
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               clear;
    logic [STAMP_W-1:0] stamp;
  } swcb_ring_ctl_t;

endpackage
`default_nettype wire

// File: src/swcb_cell.sv
`default_nettype none
module swcb_cell (
  input  wire logic                        clk,
  input  wire logic                        shift,
  input  wire logic                        load,
  input  wire logic [swcb_pkg::STAMP_W-1:0] nbr_stamp,
  input  wire logic [swcb_pkg::STAMP_W-1:0] load_stamp,
  output logic      [swcb_pkg::STAMP_W-1:0] stamp
);
  import swcb_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      stamp <= load_stamp;
    end else if (shift) begin
      stamp <= nbr_stamp;
    end
  end

endmodule
`default_nettype wire

// File: src/swcb_chain.sv
`default_nettype none
// Failure stamps, oldest always in cell 0, valid ones in cells 0..count-1.
module swcb_chain #(
  parameter int SLOTS = swcb_pkg::FAIL_SLOTS_DEF,
  localparam int CW = $clog2(SLOTS + 1),
  localparam int AW = $clog2(SLOTS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire swcb_pkg::swcb_ring_ctl_t     ctl,
  output logic      [swcb_pkg::STAMP_W-1:0] oldest,
  output logic      [CW-1:0]                count
);
  import swcb_pkg::*;

  logic [STAMP_W-1:0] stamps [SLOTS];
  logic               full;
  logic               shift_all;
  logic [CW-1:0]      count_next;

  assign full      = (count == CW'(SLOTS));
  // a push into a full ring drops the oldest stamp
  assign shift_all = ctl.pop || (ctl.push && full);
  assign oldest    = stamps[0];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic load_i;
    logic [STAMP_W-1:0] nbr_i;

    assign load_i = ctl.push && (full ? (i == SLOTS - 1) : (count[AW-1:0] == AW'(i)));
    if (i == SLOTS - 1) begin : g_last
      assign nbr_i = stamps[i];
    end else begin : g_mid
      assign nbr_i = stamps[i+1];
    end

    swcb_cell u_cell (
      .clk        (clk),
      .shift      (shift_all),
      .load       (load_i),
      .nbr_stamp  (nbr_i),
      .load_stamp (ctl.stamp),
      .stamp      (stamps[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.push && !full) begin
      count_next = count + CW'(1);
    end else if (ctl.pop && count != '0) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: src/sliding_window_circuit_breaker_unit.sv
`default_nettype none
// Three-state circuit breaker (closed, open, half-open) with a sliding window
// of failure stamps. One result word per input word. Queries, success reports
// and force-open pass from accept to the emit step and the result register. A
// failure report first walks the prune step, which drops the expired stamps:
// the stamps sit in a chain of FAIL_SLOTS cells with the oldest in the first
// cell, and the age check retires one stamp per cycle. A new word is taken
// only when the previous one has been handed to the result register; a
// result may wait there while the next word is processed.
module sliding_window_circuit_breaker_unit #(
  parameter int FAIL_SLOTS = swcb_pkg::FAIL_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [swcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swcb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire swcb_pkg::swcb_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output swcb_pkg::swcb_out_t                  out_data
);
  import swcb_pkg::*;

  localparam int CW = $clog2(FAIL_SLOTS + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  // configuration
  logic [6:0]  fail_limit;
  logic [7:0]  success_limit;
  logic [31:0] open_timeout_ms;
  logic [31:0] window_len_ms;
  logic [6:0]  catastrophe_limit;
  logic        hints_enable;

  // breaker state
  swcb_fsm_t   fsm, fsm_next;
  swcb_mode_t  mode, mode_next;
  logic [7:0]  success_run, success_run_next;
  logic [31:0] change_time, change_time_next;
  logic        hint_flag, hint_flag_next;
  logic [31:0] stat_rejected, stat_rejected_next;
  logic [31:0] stat_transitions, stat_transitions_next;
  logic [31:0] stat_failures, stat_failures_next;
  logic [31:0] stat_successes, stat_successes_next;
  logic        allowed_q, allowed_q_next;
  logic [31:0] now_q, now_q_next;
  logic        out_valid_next;
  logic        out_load;

  swcb_ring_ctl_t     ring_ctl;
  logic [STAMP_W-1:0] ring_oldest;
  logic [CW-1:0]      ring_count;
  logic [LW-1:0]      count_ext;
  logic [7:0]         run_inc;
  logic               expired;
  swcb_out_t          rsp;

  swcb_chain #(
    .SLOTS (FAIL_SLOTS)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ring_ctl),
    .oldest (ring_oldest),
    .count  (ring_count)
  );

  assign count_ext = LW'(ring_count);
  assign run_inc   = (success_run == 8'hFF) ? success_run : success_run + 8'd1;
  assign expired   = (ring_count != '0) && ((now_q - ring_oldest) > window_len_ms);
  assign in_stall  = (fsm != ST_IDLE);

  always_comb begin
    rsp.allowed           = allowed_q;
    rsp.breaker_state     = mode;
    rsp.window_failures   = count_ext[6:0];
    rsp.catastrophe_hint  = hint_flag;
    rsp.rejected_total    = stat_rejected;
    rsp.transitions_total = stat_transitions;
    rsp.failures_total    = stat_failures;
    rsp.successes_total   = stat_successes;
  end

  always_comb begin
    fsm_next              = fsm;
    mode_next             = mode;
    success_run_next      = success_run;
    change_time_next      = change_time;
    hint_flag_next        = hint_flag;
    stat_rejected_next    = stat_rejected;
    stat_transitions_next = stat_transitions;
    stat_failures_next    = stat_failures;
    stat_successes_next   = stat_successes;
    allowed_q_next        = allowed_q;
    now_q_next            = now_q;
    ring_ctl              = '0;
    out_load              = 1'b0;

    case (fsm)
      ST_IDLE: begin
        if (in_valid) begin
          now_q_next     = in_data.now_ms;
          allowed_q_next = 1'b0;
          fsm_next       = ST_EMIT;
          case (in_data.req_type)
            REQ_ALLOW: begin
              if (hints_enable && hint_flag) begin
                stat_rejected_next = (stat_rejected == '1) ? stat_rejected
                                                           : stat_rejected + 32'd1;
              end else if (mode == MODE_OPEN) begin
                if ((in_data.now_ms - change_time) >= open_timeout_ms) begin
                  mode_next             = MODE_HALF;
                  change_time_next      = in_data.now_ms;
                  stat_transitions_next = (stat_transitions == '1) ? stat_transitions
                                                                   : stat_transitions + 32'd1;
                  success_run_next      = '0;
                  allowed_q_next        = 1'b1;
                end else begin
                  stat_rejected_next = (stat_rejected == '1) ? stat_rejected
                                                             : stat_rejected + 32'd1;
                end
              end else begin
                allowed_q_next = 1'b1;
              end
            end
            REQ_SUCCESS: begin
              stat_successes_next = (stat_successes == '1) ? stat_successes
                                                           : stat_successes + 32'd1;
              if (mode == MODE_HALF) begin
                success_run_next = run_inc;
                if (run_inc >= success_limit) begin
                  // recovery: close, forget the window
                  mode_next             = MODE_CLOSED;
                  change_time_next      = in_data.now_ms;
                  stat_transitions_next = (stat_transitions == '1) ? stat_transitions
                                                                   : stat_transitions + 32'd1;
                  success_run_next      = '0;
                  if (hints_enable) begin
                    hint_flag_next = 1'b0;
                  end
                  ring_ctl.clear = 1'b1;
                end
              end
            end
            REQ_FAIL: begin
              stat_failures_next = (stat_failures == '1) ? stat_failures
                                                         : stat_failures + 32'd1;
              ring_ctl.push  = 1'b1;
              ring_ctl.stamp = in_data.now_ms;
              fsm_next       = ST_PRUNE;
            end
            default: begin
              // force open
              if (mode != MODE_OPEN) begin
                mode_next             = MODE_OPEN;
                change_time_next      = in_data.now_ms;
                stat_transitions_next = (stat_transitions == '1) ? stat_transitions
                                                                 : stat_transitions + 32'd1;
              end
            end
          endcase
        end
      end
      ST_PRUNE: begin
        if (expired) begin
          ring_ctl.pop = 1'b1;
        end else begin
          fsm_next = ST_EMIT;
          if (mode == MODE_HALF) begin
            mode_next             = MODE_OPEN;
            change_time_next      = now_q;
            stat_transitions_next = (stat_transitions == '1) ? stat_transitions
                                                             : stat_transitions + 32'd1;
            success_run_next      = '0;
          end else if (mode == MODE_CLOSED) begin
            if (count_ext >= LW'(fail_limit)) begin
              mode_next             = MODE_OPEN;
              change_time_next      = now_q;
              stat_transitions_next = (stat_transitions == '1) ? stat_transitions
                                                               : stat_transitions + 32'd1;
            end
            if (hints_enable && (count_ext >= LW'(catastrophe_limit))) begin
              hint_flag_next = 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          fsm_next = ST_IDLE;
        end
      end
      default: begin
        fsm_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit        <= FAIL_LIMIT_RST;
      success_limit     <= SUCCESS_LIMIT_RST;
      open_timeout_ms   <= OPEN_TIMEOUT_RST;
      window_len_ms     <= WINDOW_LEN_RST;
      catastrophe_limit <= CATASTROPHE_RST;
      hints_enable      <= HINTS_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAIL_LIMIT:    fail_limit        <= cfg_data[6:0];
        CFG_SUCCESS_LIMIT: success_limit     <= cfg_data[7:0];
        CFG_OPEN_TIMEOUT:  open_timeout_ms   <= cfg_data[31:0];
        CFG_WINDOW_LEN:    window_len_ms     <= cfg_data[31:0];
        CFG_CATASTROPHE:   catastrophe_limit <= cfg_data[6:0];
        CFG_HINTS_ENABLE:  hints_enable      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm              <= ST_IDLE;
      mode             <= MODE_CLOSED;
      success_run      <= '0;
      change_time      <= '0;
      hint_flag        <= 1'b0;
      stat_rejected    <= '0;
      stat_transitions <= '0;
      stat_failures    <= '0;
      stat_successes   <= '0;
      out_valid        <= 1'b0;
    end else begin
      fsm              <= fsm_next;
      mode             <= mode_next;
      success_run      <= success_run_next;
      change_time      <= change_time_next;
      hint_flag        <= hint_flag_next;
      stat_rejected    <= stat_rejected_next;
      stat_transitions <= stat_transitions_next;
      stat_failures    <= stat_failures_next;
      stat_successes   <= stat_successes_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    allowed_q <= allowed_q_next;
    now_q     <= now_q_next;
    if (out_load) begin
      out_data <= rsp;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CW'(FAIL_SLOTS))
    else $error("failure ring count exceeds its slots");

  a_fail_prunes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.req_type == REQ_FAIL) |=> (fsm == ST_PRUNE))
    else $error("failure word did not enter the prune walk");

  a_closed_run: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_CLOSED) |-> (success_run == 8'd0))
    else $error("closed breaker carries a half-open success run");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(fsm) == ST_EMIT))
    else $error("result word appeared outside the emit step");

  a_prune_no_push: assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_PRUNE) |-> !ring_ctl.push && !ring_ctl.clear)
    else $error("ring written during the prune walk");
`endif

endmodule
`default_nettype wire

// File: test/tb_sliding_window_circuit_breaker_unit.sv
`timescale 1ns / 1ps

module tb_sliding_window_circuit_breaker_unit;
  import swcb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic [6:0]  fail_lim;
    logic [7:0]  succ_lim;
    logic [31:0] open_to;
    logic [31:0] win;
    logic [6:0]  cat_lim;
    logic        hints;
  } brk_setup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  swcb_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  swcb_out_t out_data;

  sliding_window_circuit_breaker_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // breaker state as predicted
  brk_setup_t setup;
  swcb_mode_t mode_q;
  logic [31:0] ring [FAIL_SLOTS_DEF];
  logic [5:0] oldest;
  logic [6:0] held;
  logic [7:0] run_len;
  logic [31:0] changed_at;
  logic hint_q;
  logic [31:0] rej_total, trans_total, fail_total, succ_total;

  // expected result words, written at accept, read at result
  swcb_out_t exp_buf [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  logic [31:0] stamp_now = '0;
  logic quiet = 1'b0;
  logic holding = 1'b0;
  event hold_off;

  function automatic brk_setup_t mk_setup(input logic [6:0] fl, input logic [7:0] sl,
                                          input logic [31:0] ot, input logic [31:0] wl,
                                          input logic [6:0] cl, input logic he);
    brk_setup_t c;
    c.fail_lim = fl;
    c.succ_lim = sl;
    c.open_to = ot;
    c.win = wl;
    c.cat_lim = cl;
    c.hints = he;
    return c;
  endfunction

  function automatic void breaker_reset();
    setup = mk_setup(FAIL_LIMIT_RST, SUCCESS_LIMIT_RST, OPEN_TIMEOUT_RST, WINDOW_LEN_RST,
                     CATASTROPHE_RST, HINTS_ENABLE_RST);
    mode_q = MODE_CLOSED;
    foreach (ring[i]) ring[i] = '0;
    oldest = '0;
    held = '0;
    run_len = '0;
    changed_at = '0;
    hint_q = 1'b0;
    rej_total = '0;
    trans_total = '0;
    fail_total = '0;
    succ_total = '0;
  endfunction

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void enter(input swcb_mode_t m, input logic [31:0] t);
    if (mode_q != m) begin
      mode_q = m;
      changed_at = t;
      trans_total = sat_up(trans_total);
    end
  endfunction

  function automatic swcb_out_t breaker_step(input swcb_in_t w);
    swcb_out_t r;
    logic [31:0] t;
    logic [31:0] age;
    logic [5:0] slot;
    swcb_mode_t prev;
    logic granted;
    t = w.now_ms;
    granted = 1'b0;
    case (swcb_req_t'(w.req_type))
      REQ_ALLOW: begin
        if (setup.hints && hint_q) begin
          rej_total = sat_up(rej_total);
        end else if (mode_q == MODE_OPEN) begin
          age = t - changed_at;
          if (age >= setup.open_to) begin
            enter(MODE_HALF, t);
            run_len = '0;
            granted = 1'b1;
          end else begin
            rej_total = sat_up(rej_total);
          end
        end else begin
          granted = 1'b1;
        end
      end
      REQ_SUCCESS: begin
        succ_total = sat_up(succ_total);
        if (mode_q == MODE_HALF) begin
          if (run_len != 8'hFF) run_len++;
          if (run_len >= setup.succ_lim) begin
            enter(MODE_CLOSED, t);
            run_len = '0;
            if (setup.hints) hint_q = 1'b0;
            held = '0;
            oldest = '0;
          end
        end
      end
      REQ_FAIL: begin
        fail_total = sat_up(fail_total);
        // full ring: newest stamp replaces the oldest
        if (held == FAIL_SLOTS_DEF) begin
          ring[oldest] = t;
          oldest++;
        end else begin
          slot = oldest + held[5:0];
          ring[slot] = t;
          held++;
        end
        age = t - ring[oldest];
        while (held != 0 && age > setup.win) begin
          oldest++;
          held--;
          age = t - ring[oldest];
        end
        prev = mode_q;
        if (prev == MODE_HALF) begin
          enter(MODE_OPEN, t);
          run_len = '0;
        end else if (prev == MODE_CLOSED) begin
          if (held >= setup.fail_lim) enter(MODE_OPEN, t);
          if (setup.hints && held >= setup.cat_lim) hint_q = 1'b1;
        end
      end
      default: begin
        enter(MODE_OPEN, t);
      end
    endcase
    r.allowed = granted;
    r.breaker_state = mode_q;
    r.window_failures = held;
    r.catastrophe_hint = hint_q;
    r.rejected_total = rej_total;
    r.transitions_total = trans_total;
    r.failures_total = fail_total;
    r.successes_total = succ_total;
    return r;
  endfunction

  function automatic string show(input swcb_out_t r);
    return $sformatf("allowed=%0b state=%0d held=%0d hint=%0b rej=%0d trans=%0d fail=%0d succ=%0d",
                     r.allowed, r.breaker_state, r.window_failures, r.catastrophe_hint,
                     r.rejected_total, r.transitions_total, r.failures_total, r.successes_total);
  endfunction

  // receiver side stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holding) begin
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 32);
    end
  end

  always begin
    @(hold_off);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    swcb_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (exp_wr == exp_rd) begin
        if (mismatch_count < 10)
          $display("result %0d with no word pending: got %s", results_seen, show(out_data));
        mismatch_count++;
      end else begin
        want = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.allowed !== want.allowed ||
            out_data.breaker_state !== want.breaker_state ||
            out_data.window_failures !== want.window_failures ||
            out_data.catastrophe_hint !== want.catastrophe_hint ||
            out_data.rejected_total !== want.rejected_total ||
            out_data.transitions_total !== want.transitions_total ||
            out_data.failures_total !== want.failures_total ||
            out_data.successes_total !== want.successes_total) begin
          if (mismatch_count < 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(out_data));
          end
          mismatch_count++;
        end
      end
    end
  end

  // entered and left just after a rising edge
  task automatic send_word(input swcb_req_t req, input logic [31:0] at_ms);
    swcb_in_t w;
    w.req_type = req;
    w.now_ms = at_ms;
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_buf[exp_wr % EXP_DEPTH] = breaker_step(w);
    exp_wr++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_setup(input brk_setup_t c);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FAIL_LIMIT;
    cfg_data <= CFG_DATA_W'(c.fail_lim);
    @(posedge clk);
    cfg_index <= CFG_SUCCESS_LIMIT;
    cfg_data <= CFG_DATA_W'(c.succ_lim);
    @(posedge clk);
    cfg_index <= CFG_OPEN_TIMEOUT;
    cfg_data <= c.open_to;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_LEN;
    cfg_data <= c.win;
    @(posedge clk);
    cfg_index <= CFG_CATASTROPHE;
    cfg_data <= CFG_DATA_W'(c.cat_lim);
    @(posedge clk);
    cfg_index <= CFG_HINTS_ENABLE;
    cfg_data <= CFG_DATA_W'(c.hints);
    @(posedge clk);
    cfg_we <= 1'b0;
    setup = c;
  endtask

  task automatic send_at(input swcb_req_t req, input logic [31:0] at_ms);
    stamp_now = at_ms;
    send_word(req, stamp_now);
  endtask

  // episodes: failure bursts, trials with successes, queries, force-open, noise
  task automatic run_traffic(input int unsigned n_items, input logic [31:0] step_max);
    int unsigned k;
    int unsigned kind;
    int unsigned reps;
    logic [31:0] gap;
    k = 0;
    while (k < n_items) begin
      kind = $urandom_range(39);
      if (kind < 16) begin
        reps = $urandom_range(1, 12);
        repeat (reps) begin
          case ($urandom_range(9))
            0: gap = setup.win;
            1: gap = setup.win + 32'd1;
            default: gap = $urandom_range(0, step_max);
          endcase
          stamp_now += gap;
          send_word(REQ_FAIL, stamp_now);
          k++;
        end
      end else if (kind < 26) begin
        case ($urandom_range(3))
          0: gap = setup.open_to - 32'd1;
          1: gap = setup.open_to;
          default: gap = setup.open_to + $urandom_range(0, step_max);
        endcase
        stamp_now += gap;
        send_word(REQ_ALLOW, stamp_now);
        k++;
        reps = $urandom_range(0, 4);
        repeat (reps) begin
          stamp_now += $urandom_range(0, step_max);
          send_word(REQ_SUCCESS, stamp_now);
          k++;
        end
      end else if (kind < 32) begin
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          stamp_now += $urandom_range(0, step_max);
          send_word(REQ_ALLOW, stamp_now);
          k++;
        end
      end else if (kind < 34) begin
        stamp_now += $urandom_range(0, step_max);
        send_word(REQ_FORCE, stamp_now);
        k++;
      end else if (kind < 39) begin
        if ($urandom_range(7) == 0) stamp_now += $urandom();
        else stamp_now += $urandom_range(0, step_max);
        send_word(swcb_req_t'($urandom_range(3)), stamp_now);
        k++;
      end else begin
        // long tight burst wraps the stamp ring
        repeat (70) begin
          stamp_now += $urandom_range(0, 1);
          send_word(REQ_FAIL, stamp_now);
          k++;
        end
      end
    end
  endtask

  task automatic run_phase(input brk_setup_t c, input int unsigned n_items,
                           input logic [31:0] step_max);
    wait_idle();
    load_setup(c);
    run_traffic(n_items, step_max);
  endtask

  // reset register values: window aging, opening, trial, reopen, recovery
  task automatic test_reset_defaults();
    send_at(REQ_ALLOW, 32'd0);
    send_at(REQ_SUCCESS, 32'd0);
    send_at(REQ_FAIL, 32'd5);
    send_at(REQ_FAIL, 32'd10);
    send_at(REQ_FAIL, 32'd20000);
    repeat (4) send_at(REQ_FAIL, 32'd20000);
    send_at(REQ_FORCE, 32'd20001);
    send_at(REQ_ALLOW, 32'd20002);
    send_at(REQ_ALLOW, 32'd50002);
    send_at(REQ_FAIL, 32'd50003);
    send_at(REQ_ALLOW, 32'd80003);
    send_at(REQ_SUCCESS, 32'd80004);
    send_at(REQ_SUCCESS, 32'd80005);
    send_at(REQ_FORCE, 32'd80006);
  endtask

  // zero limits, time wrap, hint set and honored, then hints switched off
  task automatic test_zero_limits_and_hints();
    wait_idle();
    load_setup(mk_setup(7'd0, 8'd0, 32'd0, 32'd0, 7'd0, 1'b1));
    send_at(REQ_ALLOW, 32'hFFFF_FFF0);
    send_at(REQ_SUCCESS, 32'hFFFF_FFF0);
    send_at(REQ_FAIL, 32'hFFFF_FFF8);
    send_at(REQ_ALLOW, 32'hFFFF_FFF9);
    send_at(REQ_FORCE, 32'hFFFF_FFFF);
    send_at(REQ_ALLOW, 32'd4);
    wait_idle();
    load_setup(mk_setup(7'd0, 8'd0, 32'd0, 32'd0, 7'd0, 1'b0));
    send_at(REQ_ALLOW, 32'd4);
    send_at(REQ_SUCCESS, 32'd5);
    send_at(REQ_FAIL, 32'd6);
    send_at(REQ_FAIL, 32'd6);
  endtask

  task automatic test_backpressure();
    wait_idle();
    -> hold_off;
    repeat (16) begin
      stamp_now += $urandom_range(0, 20);
      send_word(swcb_req_t'($urandom_range(3)), stamp_now);
    end
  endtask

  task automatic test_mixed_traffic();
    run_phase(mk_setup(7'd3, 8'd2, 32'd200, 32'd1000, 7'd5, 1'b1), 320, 32'd60);
    run_phase(mk_setup(7'($urandom_range(1, 64)), 8'($urandom_range(1, 8)),
                       $urandom_range(0, 500), $urandom_range(0, 2000),
                       7'($urandom_range(1, 64)), 1'($urandom_range(1))),
              250, $urandom_range(1, 100));
  endtask

  task automatic test_window_extremes();
    run_phase(mk_setup(7'd64, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64, 1'b1), 250, 32'd1000);
    run_phase(mk_setup(7'd1, 8'd1, 32'd0, 32'd0, 7'd1, 1'b1), 250, 32'd3);
  endtask

  task automatic test_idle_free_stretch();
    wait_idle();
    load_setup(mk_setup(7'd4, 8'd3, 32'd100, 32'd500, 7'd3, 1'b0));
    quiet <= 1'b1;
    run_traffic(150, 32'd40);
    quiet <= 1'b0;
    run_traffic(150, 32'd40);
  endtask

  task automatic test_limits_beyond_ring();
    run_phase(mk_setup(7'd127, 8'd4, 32'd50, 32'd5000, 7'd127, 1'b1), 250, 32'd30);
    run_phase(mk_setup(7'd0, 8'd0, 32'd20, 32'd100, 7'd70, 1'b1), 200, 32'd10);
  endtask

  initial begin
    breaker_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_limits_and_hints();
    test_backpressure();
    test_mixed_traffic();
    test_window_extremes();
    test_idle_free_stretch();
    test_limits_beyond_ring();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_sliding_window_circuit_breaker_unit passed");
    end else begin
      $display("tb_sliding_window_circuit_breaker_unit failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_sliding_window_circuit_breaker_unit failed");
    $finish;
  end

endmodule

// File: filelist.f
src/swcb_pkg.sv
src/swcb_cell.sv
src/swcb_chain.sv
src/sliding_window_circuit_breaker_unit.sv
test/tb_sliding_window_circuit_breaker_unit.sv
